FILE: sv/ttwf_pkg.sv
package ttwf_pkg;

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_INVALIDATE = 2'd2
  } op_e;

  typedef enum logic {
    KIND_TILE  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMP   = 3'b010,
    ST_SWEEP = 3'b100
  } state_e;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] palette;
  } tile_t;

  localparam tile_t BlankTile   = '{glyph: 8'h20, palette: 8'h00};
  localparam tile_t InvalidTile = '{glyph: 8'h00, palette: 8'hff};

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    tile_t wdata;
  } mem_ctl_t;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] col;
    logic [4:0] row;
    logic [7:0] glyph;
    logic [7:0] palette;
  } result_t;

endpackage

FILE: sv/text_tile_write_filter.sv
// Text tile write filter. Input beats on the s_axis channel carry an operation in
// tuser: a put of one glyph and palette at a column and row, a screen clear, or an
// invalidate of the shadow store. Output beats on m_axis carry either a tile write
// (tuser 0) or a screen-clear command (tuser 1, tdata zero).
// A put that lies inside the grid reads its shadow entry and is emitted and stored
// only when the pair differs; the single-port shadow memory is read in the idle state
// and the compare and write back follow in the compare state.
// A put outside the grid, or an unknown operation, gives nothing and leaves the block idle.
// Clear and invalidate rewrite every entry, one per cycle, while s_axis_tready is low;
// clear emits its command beat at the start of that pass, or as soon as the output
// stage is free, and the pass does not end before that beat has been loaded.
// After reset the block runs the same pass with the invalid pair (glyph 0,
// palette 255), so s_axis_tready stays low until that pass has ended.
// A registered output stage holds one result; while the receiver stalls a new put is
// still accepted, and a differing one waits in the compare step for the output stage.
module text_tile_write_filter
  import ttwf_pkg::*;
#(
  parameter int GRID_WIDTH  = 40,
  parameter int GRID_HEIGHT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // col[7:0], row[15:8], glyph[23:16], palette[31:24]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_col[5:0], out_row[10:6], out_glyph[18:11],
                                     // out_palette[26:19], zero[31:27]
  output logic [0:0]  m_axis_tuser   // kind[0]
);

  localparam int Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;

  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_addr;
  tile_t            mem_rdata;
  logic             out_free;
  logic             out_load;
  result_t          out_res;

  logic             m_valid_q;
  result_t          res_q;

  ttwf_ctrl #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_col_i    (s_axis_tdata[7:0]),
    .in_row_i    (s_axis_tdata[15:8]),
    .in_glyph_i  (s_axis_tdata[23:16]),
    .in_palette_i(s_axis_tdata[31:24]),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_rdata_i (mem_rdata),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_res_o   (out_res)
  );

  ttwf_mem #(
    .Depth(Cells),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .addr_i (mem_addr),
    .rdata_o(mem_rdata)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= out_res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.palette, res_q.glyph, res_q.row, res_q.col};
  assign m_axis_tuser  = res_q.kind;

endmodule

FILE: sv/ttwf_mem.sv
module ttwf_mem
  import ttwf_pkg::*;
#(
  parameter int Depth = 1280,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] addr_i,
  output tile_t            rdata_o
);

  tile_t mem_q [Depth];
  tile_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= ctl_i.wdata;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ttwf_ctrl.sv
module ttwf_ctrl
  import ttwf_pkg::*;
#(
  parameter int GRID_WIDTH  = 40,
  parameter int GRID_HEIGHT = 32,
  parameter int AddrW       = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_op_i,
  input  logic [7:0]       in_col_i,
  input  logic [7:0]       in_row_i,
  input  logic [7:0]       in_glyph_i,
  input  logic [7:0]       in_palette_i,
  output mem_ctl_t         mem_ctl_o,
  output logic [AddrW-1:0] mem_addr_o,
  input  tile_t            mem_rdata_i,
  input  logic             out_free_i,
  output logic             out_load_o,
  output result_t          out_res_o
);

  localparam int Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int MulW  = AddrW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Cells - 1);

  state_e           state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  tile_t            fill_q, fill_d;
  logic             clr_pend_q, clr_pend_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [5:0]       col_q, col_d;
  logic [4:0]       row_q, row_d;
  tile_t            tile_q, tile_d;

  logic             in_grid;
  logic [MulW-1:0]  in_addr;

  assign in_grid = (in_col_i < 8'(GRID_WIDTH)) && (in_row_i < 8'(GRID_HEIGHT));
  assign in_addr = MulW'(in_row_i[4:0]) * MulW'(GRID_WIDTH) + MulW'(in_col_i[5:0]);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    clr_pend_d = clr_pend_q;
    addr_d     = addr_q;
    col_d      = col_q;
    row_d      = row_q;
    tile_d     = tile_q;
    in_ready_o = (state_q == ST_IDLE);
    mem_ctl_o  = '{rd_en: 1'b0, wr_en: 1'b0, wdata: tile_q};
    mem_addr_o = addr_q;
    out_load_o = 1'b0;
    out_res_o  = '{kind: KIND_TILE, col: col_q, row: row_q,
                   glyph: tile_q.glyph, palette: tile_q.palette};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(in_op_i))
            OP_PUT: begin
              if (in_grid) begin
                mem_ctl_o.rd_en = 1'b1;
                mem_addr_o      = in_addr[AddrW-1:0];
                addr_d          = in_addr[AddrW-1:0];
                col_d           = in_col_i[5:0];
                row_d           = in_row_i[4:0];
                tile_d          = '{glyph: in_glyph_i, palette: in_palette_i};
                state_d         = ST_CMP;
              end
            end
            OP_CLEAR: begin
              fill_d     = BlankTile;
              clr_pend_d = 1'b1;
              cnt_d      = '0;
              state_d    = ST_SWEEP;
            end
            OP_INVALIDATE: begin
              fill_d  = InvalidTile;
              cnt_d   = '0;
              state_d = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        if (mem_rdata_i == tile_q) begin
          state_d = ST_IDLE;
        end else if (out_free_i) begin
          mem_ctl_o.wr_en = 1'b1;
          out_load_o      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_ctl_o.wdata = fill_q;
        mem_addr_o      = cnt_q;
        out_res_o       = '{kind: KIND_CLEAR, col: '0, row: '0, glyph: '0, palette: '0};
        if (clr_pend_q && out_free_i) begin
          out_load_o = 1'b1;
          clr_pend_d = 1'b0;
        end
        if (cnt_q != LastAddr) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!clr_pend_q || out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      cnt_q      <= '0;
      fill_q     <= InvalidTile;
      clr_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fill_q     <= fill_d;
      clr_pend_q <= clr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    col_q  <= col_d;
    row_q  <= row_d;
    tile_q <= tile_d;
  end

endmodule

FILE: sv/ttwf_checker.sv
module ttwf_checker
  import ttwf_pkg::*;
#(
  parameter int GRID_WIDTH  = 40,
  parameter int GRID_HEIGHT = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic in_beat;
  logic put_outside;

  assign in_beat     = s_axis_tvalid && s_axis_tready;
  assign put_outside = (s_axis_tuser == OP_PUT) &&
                       ((s_axis_tdata[7:0] >= 8'(GRID_WIDTH)) ||
                        (s_axis_tdata[15:8] >= 8'(GRID_HEIGHT)));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled output beat changed.");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser == OP_CLEAR || s_axis_tuser == OP_INVALIDATE) |=>
      !s_axis_tready)
    else $error("Store pass did not block the input.");

  a_drop_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && put_outside |=> s_axis_tready)
    else $error("Put outside the grid stalled the input.");

  a_tile_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == KIND_TILE |->
      (m_axis_tdata[5:0] < 6'(GRID_WIDTH)) && (m_axis_tdata[10:6] < 5'(GRID_HEIGHT)) ||
      (GRID_WIDTH == 64) && (m_axis_tdata[10:6] < 5'(GRID_HEIGHT)) ||
      (GRID_HEIGHT == 32) && (m_axis_tdata[5:0] < 6'(GRID_WIDTH)) ||
      (GRID_WIDTH == 64) && (GRID_HEIGHT == 32))
    else $error("Tile write outside the grid.");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == KIND_CLEAR |-> m_axis_tdata == 32'd0)
    else $error("Clear command with nonzero data.");

endmodule

bind text_tile_write_filter ttwf_checker #(
  .GRID_WIDTH (GRID_WIDTH),
  .GRID_HEIGHT(GRID_HEIGHT)
) u_checker (.*);

FILE: tb/text_tile_write_filter_test.sv
`timescale 1ns / 1ps

module text_tile_write_filter_test;
  import ttwf_pkg::*;

  localparam int GRID_W = 40;
  localparam int GRID_H = 32;
  localparam int CELLS = GRID_W * GRID_H;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // col[7:0], row[15:8], glyph[23:16], palette[31:24]
  logic [1:0]  s_axis_tuser = '0;  // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // out_col[5:0], out_row[10:6], out_glyph[18:11],
                                   // out_palette[26:19], zero[31:27]
  logic [0:0]  m_axis_tuser;       // kind[0]

  text_tile_write_filter #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  class TileFilterScoreboard;
    logic [7:0] glyph_store[CELLS];
    logic [7:0] palette_store[CELLS];
    result_t    write_q[$];
    int         mismatches;
    int         checked;
    int         filtered_puts;

    function new();
      mismatches = 0;
      checked = 0;
      filtered_puts = 0;
      fill(InvalidTile);
    endfunction

    function void fill(tile_t t);
      for (int i = 0; i < CELLS; i++) begin
        glyph_store[i] = t.glyph;
        palette_store[i] = t.palette;
      end
    endfunction

    function tile_t stored_tile(int c, int r);
      tile_t t;
      t.glyph = glyph_store[r * GRID_W + c];
      t.palette = palette_store[r * GRID_W + c];
      return t;
    endfunction

    function int pending();
      return write_q.size();
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] data);
      result_t exp_write;
      int c, r, idx;
      c = int'(data[7:0]);
      r = int'(data[15:8]);
      exp_write = '0;
      case (op)
        OP_CLEAR: begin
          fill(BlankTile);
          exp_write.kind = KIND_CLEAR;
          write_q.push_back(exp_write);
        end
        OP_INVALIDATE: fill(InvalidTile);
        OP_PUT: begin
          if (c < GRID_W && r < GRID_H) begin
            idx = r * GRID_W + c;
            if (glyph_store[idx] == data[23:16] && palette_store[idx] == data[31:24]) begin
              filtered_puts++;
            end else begin
              glyph_store[idx] = data[23:16];
              palette_store[idx] = data[31:24];
              exp_write.kind = KIND_TILE;
              exp_write.col = c[5:0];
              exp_write.row = r[4:0];
              exp_write.glyph = data[23:16];
              exp_write.palette = data[31:24];
              write_q.push_back(exp_write);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] data, logic [0:0] user);
      result_t exp_write;
      bit bad;
      checked++;
      if (write_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output beat: kind %0d data %h", user, data);
        return;
      end
      exp_write = write_q.pop_front();
      bad = (user[0] != exp_write.kind) || (data[5:0] != exp_write.col) ||
            (data[10:6] != exp_write.row) || (data[18:11] != exp_write.glyph) ||
            (data[26:19] != exp_write.palette) || (data[31:27] != 5'd0);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Output beat differs: expected kind %0d col %0d row %0d glyph %h ",
                    "pal %h, got kind %0d col %0d row %0d glyph %h pal %h pad %h"},
                   exp_write.kind, exp_write.col, exp_write.row, exp_write.glyph,
                   exp_write.palette, user[0], data[5:0], data[10:6], data[18:11],
                   data[26:19], data[31:27]);
      end
    endfunction
  endclass

  TileFilterScoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit start_hold = 1'b0;
  int hold_left = 0;
  int put_count = 0;
  int clear_count = 0;
  int invalidate_count = 0;
  int undefined_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
    if (start_hold) begin
      hold_left = HOLD_CYCLES;
      start_hold = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [31:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, data);
    case (op)
      OP_PUT: put_count++;
      OP_CLEAR: clear_count++;
      OP_INVALIDATE: invalidate_count++;
      default: undefined_count++;
    endcase
  endtask

  task automatic send_put(input int c, input int r, input logic [7:0] g, input logic [7:0] p);
    logic [7:0] c8, r8;
    c8 = 8'(c);
    r8 = 8'(r);
    send_beat(OP_PUT, {p, g, r8, c8});
  endtask

  task automatic send_random_item();
    int pick, c, r, sel;
    tile_t t;
    logic [7:0] g, p;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_beat(OP_CLEAR, $urandom());
    end else if (pick < 4) begin
      send_beat(OP_INVALIDATE, $urandom());
    end else if (pick < 7) begin
      send_beat(OP_UNDEFINED, $urandom());
    end else if (pick < 15) begin
      c = $urandom_range(0, 255);
      r = $urandom_range(0, 255);
      if (c < GRID_W && r < GRID_H) begin
        if ($urandom_range(0, 1)) c = $urandom_range(GRID_W, 255);
        else r = $urandom_range(GRID_H, 255);
      end
      send_put(c, r, 8'($urandom()), 8'($urandom()));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        c = $urandom_range(0, 3);
        r = $urandom_range(0, 3);
      end else begin
        c = $urandom_range(0, GRID_W - 1);
        r = $urandom_range(0, GRID_H - 1);
      end
      sel = $urandom_range(0, 9);
      t = sb.stored_tile(c, r);
      if (sel < 3) begin
        g = t.glyph;
        p = t.palette;
      end else if (sel < 5) begin
        g = $urandom_range(0, 2) == 0 ? 8'h00 : ($urandom_range(0, 1) ? 8'h20 : 8'hff);
        p = $urandom_range(0, 1) ? 8'h00 : 8'hff;
      end else begin
        g = 8'($urandom());
        p = 8'($urandom());
      end
      send_put(c, r, g, p);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (CELLS + 20) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_put(0, 0, 8'h00, 8'hff);
    send_put(0, 0, 8'h00, 8'h00);
    send_put(0, 0, 8'h00, 8'h00);
    send_put(GRID_W - 1, GRID_H - 1, 8'hff, 8'hff);
    send_put(GRID_W - 1, GRID_H - 1, 8'hff, 8'hfe);
    send_put(GRID_W, 0, 8'h41, 8'h01);
    send_put(0, GRID_H, 8'h41, 8'h01);
    send_put(255, 255, 8'hff, 8'hff);
    send_put(63, 31, 8'h42, 8'h02);
    send_beat(OP_UNDEFINED, 32'hffff_ffff);
    send_beat(OP_CLEAR, 32'h0000_0000);
    send_put(5, 5, 8'h20, 8'h00);
    send_put(5, 5, 8'h21, 8'h00);
    send_put(5, 5, 8'h00, 8'hff);
    send_beat(OP_INVALIDATE, 32'hffff_ffff);
    send_put(5, 5, 8'h00, 8'hff);
    send_put(5, 5, 8'h20, 8'h00);
    send_beat(OP_CLEAR, 32'hffff_ffff);
    send_beat(OP_CLEAR, 32'h0000_0000);
    send_put(0, GRID_H - 1, 8'h00, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int n = 0; n < 258; n++) begin
        if (phase == 0 && n == 100) start_hold = 1'b1;
        if (phase == 0 && n >= 100 && n < 140)
          send_put($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                   8'($urandom()), 8'($urandom()));
        else
          send_random_item();
      end
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end

    wait_drained();
    $display("Stimulus: %0d puts (%0d filtered), %0d clears, %0d invalidates, %0d unknown.",
             put_count, sb.filtered_puts, clear_count, invalidate_count, undefined_count);
    $display("Output beats checked: %0d, with gaps and stalls on both sides and one long stall.",
             sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d output beats still outstanding.", sb.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
